// ===== hdl/mars_pkg.sv =====
`timescale 1ns / 1ps

package mars_pkg;

  localparam int unsigned FAST_DEPTH_DEF = 64;
  localparam int unsigned SLOW_DEPTH_DEF = 256;

  localparam int unsigned PRICE_W    = 48;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FWIN_W     = 7;
  localparam int unsigned SWIN_W     = 9;
  localparam int unsigned WGT_W      = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;

  // shared unit operand widths
  localparam int unsigned DIV_W = 88;
  localparam int unsigned OPB_W = 64;
  localparam int unsigned RS_W  = 63;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_KIND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_WEIGHT = 2'd3;

  // indicator kinds
  localparam logic [KIND_W-1:0] KIND_SMA       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RSI       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RSI_RATIO = 3'd7;

  // mean flavor, low bits of the kind
  localparam logic [1:0] MEAN_SMA = 2'd0;
  localparam logic [1:0] MEAN_WMA = 2'd1;

  // fixed point constants, scale 10^8
  localparam logic [63:0] COIN      = 64'd100000000;
  localparam logic [63:0] HALF_COIN = 64'd50000000;
  localparam logic [63:0] RSI_TOP   = 64'd10000000000;
  localparam logic [63:0] COIN_SQ   = 64'd10000000000000000;
  localparam logic [63:0] COIN_E18  = 64'd1000000000000000000;
  localparam logic [PRICE_W-1:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [RS_W-1:0]    RS_CAP = 63'h4000_0000_0000_0000;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_e;

  function automatic logic [PRICE_W-1:0] sat48(input logic [DIV_W-1:0] v);
    return (|v[DIV_W-1:PRICE_W]) ? MAX48 : v[PRICE_W-1:0];
  endfunction

  function automatic logic [RS_W-1:0] sat62(input logic [DIV_W-1:0] v);
    logic over;
    over = (|v[DIV_W-1:RS_W]) || (v[RS_W-1] && (|v[RS_W-2:0]));
    return over ? RS_CAP : v[RS_W-1:0];
  endfunction

endpackage

// ===== hdl/moving_average_rsi_signal.sv =====
// each item runs bookkeeping states, divisions and multiplies in the shared unit, and for a
// weighted mean a walk over the samples of the window
// throughput: one item at a time; the next item is taken once the result sits in the output register
// reset (async, active low): registers to defaults, all windows and rsi averages empty
`timescale 1ns / 1ps

module moving_average_rsi_signal #(
  parameter int unsigned FAST_DEPTH = mars_pkg::FAST_DEPTH_DEF,
  parameter int unsigned SLOW_DEPTH = mars_pkg::SLOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mars_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mars_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mars_pkg::PRICE_W-1:0]     sample_price_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mars_pkg::PRICE_W-1:0]     signal_value_o,
  output logic                             signal_ready_o
);
  import mars_pkg::*;

  localparam int unsigned MAX_DEPTH = (FAST_DEPTH > SLOW_DEPTH) ? FAST_DEPTH : SLOW_DEPTH;
  localparam int unsigned WIN_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned FA_W   = $clog2(FAST_DEPTH);
  localparam int unsigned SA_W   = $clog2(SLOW_DEPTH);
  localparam int unsigned TOT_W  = PRICE_W + WIN_W;
  localparam int unsigned WT_W   = 2 * WIN_W;
  localparam int unsigned PROD_W = PRICE_W + WT_W;
  localparam int unsigned T_W    = 3 * WIN_W;
  localparam int unsigned SUM_W  = PRICE_W + 3 * WIN_W;
  localparam int unsigned UCNT_W = $clog2(DIV_W + 1);

  // sequencer states
  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE      = 5'd0;
  localparam logic [ST_W-1:0] S_PUSH      = 5'd1;
  localparam logic [ST_W-1:0] S_PUSH_OLD  = 5'd2;
  localparam logic [ST_W-1:0] S_RSI_CHK   = 5'd3;
  localparam logic [ST_W-1:0] S_RSI_WARM  = 5'd4;
  localparam logic [ST_W-1:0] S_WARM_CHK  = 5'd5;
  localparam logic [ST_W-1:0] S_WDIV_G    = 5'd6;
  localparam logic [ST_W-1:0] S_WDIV_L    = 5'd7;
  localparam logic [ST_W-1:0] S_AMUL_G    = 5'd8;
  localparam logic [ST_W-1:0] S_ADIV_G    = 5'd9;
  localparam logic [ST_W-1:0] S_AMUL_L    = 5'd10;
  localparam logic [ST_W-1:0] S_ADIV_L    = 5'd11;
  localparam logic [ST_W-1:0] S_PUSH_END  = 5'd12;
  localparam logic [ST_W-1:0] S_EVAL      = 5'd13;
  localparam logic [ST_W-1:0] S_RS_MUL    = 5'd14;
  localparam logic [ST_W-1:0] S_RS_DIV    = 5'd15;
  localparam logic [ST_W-1:0] S_RSI_DIV   = 5'd16;
  localparam logic [ST_W-1:0] S_RRV_DIV   = 5'd17;
  localparam logic [ST_W-1:0] S_WALK      = 5'd18;
  localparam logic [ST_W-1:0] S_MEAN_DIV  = 5'd19;
  localparam logic [ST_W-1:0] S_EVAL_END  = 5'd20;
  localparam logic [ST_W-1:0] S_RAT_MUL   = 5'd21;
  localparam logic [ST_W-1:0] S_RAT_DIV   = 5'd22;
  localparam logic [ST_W-1:0] S_RAT_MUL2  = 5'd23;
  localparam logic [ST_W-1:0] S_RAT_DIV2  = 5'd24;
  localparam logic [ST_W-1:0] S_FINAL     = 5'd25;

  // ---------------------------------------------------------------- config
  logic [KIND_W-1:0] signal_kind_q;
  logic [FWIN_W-1:0] fast_window_q;
  logic [SWIN_W-1:0] slow_window_q;
  logic [WGT_W-1:0]  ratio_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signal_kind_q  <= KIND_SMA;
      fast_window_q  <= FWIN_W'(1);
      slow_window_q  <= '0;
      ratio_weight_q <= WGT_W'(COIN);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SIGNAL_KIND:  signal_kind_q  <= cfg_data_i[KIND_W-1:0];
        REG_FAST_WINDOW:  fast_window_q  <= cfg_data_i[FWIN_W-1:0];
        REG_SLOW_WINDOW:  slow_window_q  <= cfg_data_i[SWIN_W-1:0];
        REG_RATIO_WEIGHT: ratio_weight_q <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective windows, clamped to the store depths (a zero fast window counts as one); weight at least COIN
  logic [WIN_W-1:0] fw_eff, sw_eff;
  logic [WGT_W-1:0] w_eff;

  always_comb begin
    if (fast_window_q == '0) begin
      fw_eff = WIN_W'(1);
    end else if (32'(fast_window_q) > FAST_DEPTH) begin
      fw_eff = WIN_W'(FAST_DEPTH);
    end else begin
      fw_eff = WIN_W'(fast_window_q);
    end
    if (32'(slow_window_q) > SLOW_DEPTH) begin
      sw_eff = WIN_W'(SLOW_DEPTH);
    end else begin
      sw_eff = WIN_W'(slow_window_q);
    end
    w_eff = (ratio_weight_q < WGT_W'(COIN)) ? WGT_W'(COIN) : ratio_weight_q;
  end

  logic       is_rsi, use_slow;
  logic [1:0] mean_kind;

  assign is_rsi    = (signal_kind_q == KIND_RSI) || (signal_kind_q == KIND_RSI_RATIO);
  assign use_slow  = signal_kind_q[2] && (sw_eff != '0);
  assign mean_kind = signal_kind_q[1:0];

  // ---------------------------------------------------------------- shared unit
  // shift-add multiply (one multiplier bit a cycle, stops when it runs out)
  // and restoring divide (one quotient bit a cycle, DIV_W quotient bits)
  logic              u_start;
  unit_op_e          u_op;
  logic [DIV_W-1:0]  u_a;
  logic [OPB_W-1:0]  u_b;

  logic              u_busy_q;
  unit_op_e          u_op_q;
  logic [UCNT_W-1:0] u_cnt_q;
  logic [DIV_W-1:0]  acc_q, ma_q;
  logic [OPB_W-1:0]  opb_q, rem_q;

  logic [OPB_W:0]    rem_sh;
  logic              rem_ge;
  logic [OPB_W:0]    rem_nx;

  assign rem_sh = {rem_q, acc_q[DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, opb_q};
  assign rem_nx = rem_ge ? (rem_sh - {1'b0, opb_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_busy_q <= 1'b0;
      u_op_q   <= OP_MUL;
      u_cnt_q  <= '0;
    end else if (u_start) begin
      u_busy_q <= 1'b1;
      u_op_q   <= u_op;
      u_cnt_q  <= UCNT_W'(DIV_W);
    end else if (u_busy_q) begin
      case (u_op_q)
        OP_MUL: begin
          if (opb_q == '0) u_busy_q <= 1'b0;
        end
        OP_DIV: begin
          u_cnt_q <= u_cnt_q - UCNT_W'(1);
          if (u_cnt_q == UCNT_W'(1)) u_busy_q <= 1'b0;
        end
        default: u_busy_q <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_start) begin
      opb_q <= u_b;
      rem_q <= '0;
      if (u_op == OP_MUL) begin
        acc_q <= '0;
        ma_q  <= u_a;
      end else begin
        acc_q <= u_a;
      end
    end else if (u_busy_q) begin
      if (u_op_q == OP_MUL) begin
        if (opb_q != '0) begin
          if (opb_q[0]) acc_q <= acc_q + ma_q;
          ma_q  <= {ma_q[DIV_W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[OPB_W-1:1]};
        end
      end else begin
        acc_q <= {acc_q[DIV_W-2:0], rem_ge};
        rem_q <= rem_nx[OPB_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- sample stores
  logic [PRICE_W-1:0] fmem [FAST_DEPTH];
  logic [PRICE_W-1:0] smem [SLOW_DEPTH];
  logic [PRICE_W-1:0] f_rd_q, s_rd_q, rdat;
  logic               mem_we, mem_re;
  logic [WIN_W-1:0]   mem_wa, mem_ra;
  logic [PRICE_W-1:0] p_q;
  logic               u_q;

  always_ff @(posedge clk_i) begin
    if (mem_we && !u_q) fmem[mem_wa[FA_W-1:0]] <= p_q;
    if (mem_re && !u_q) f_rd_q <= fmem[mem_ra[FA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && u_q) smem[mem_wa[SA_W-1:0]] <= p_q;
    if (mem_re && u_q) s_rd_q <= smem[mem_ra[SA_W-1:0]];
  end

  assign rdat = u_q ? s_rd_q : f_rd_q;

  // ---------------------------------------------------------------- window state
  // index 0 is the fast window, 1 the slow window; stores are circular from head
  logic [ST_W-1:0]    state_q, state_d;
  logic               u_d;
  logic [PRICE_W-1:0] p_d;
  logic [WIN_W-1:0]   cnt_q [2], cnt_d [2];
  logic [WIN_W-1:0]   head_q [2], head_d [2];
  logic [TOT_W-1:0]   tot_q [2], tot_d [2];
  logic [PRICE_W-1:0] ag_q [2], ag_d [2];
  logic [PRICE_W-1:0] al_q [2], al_d [2];
  logic [TOT_W-1:0]   wg_q [2], wg_d [2];
  logic [TOT_W-1:0]   wl_q [2], wl_d [2];
  logic [WIN_W-1:0]   wc_q [2], wc_d [2];
  logic [PRICE_W-1:0] last_q [2], last_d [2];
  logic [PRICE_W-1:0] val_q [2], val_d [2];
  logic [PRICE_W-1:0] g_q, g_d, l_q, l_d;
  logic [RS_W-1:0]    rs_c;
  logic               big_q, big_d;
  logic [PRICE_W-1:0] res_q, res_d;

  // weighted walk pipeline: address, then data and weight, then product
  logic [WIN_W-1:0]   wptr_q, wptr_d;
  logic [WIN_W:0]     k_q, k_d;
  logic               v1_q, v1_d, v2_q, v2_d;
  logic [WT_W-1:0]    wt1_q, wt1_d, wk;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [SUM_W-1:0]   s_q, s_d;
  logic [T_W-1:0]     t_q, t_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [PRICE_W-1:0] out_val_q, out_val_d;
  logic               out_rdy_q, out_rdy_d;

  logic [1:0]         ok;
  logic               rdy;

  assign ok[0] = (cnt_q[0] != '0) && (ag_q[0] != '0) && (al_q[0] != '0);
  assign ok[1] = (cnt_q[1] != '0) && (ag_q[1] != '0) && (al_q[1] != '0);
  assign rs_c  = sat62(acc_q);

  // ready flag of the finished item
  always_comb begin
    rdy = (cnt_q[0] >= fw_eff) && (!is_rsi || ok[0]);
    if (signal_kind_q[2] && (signal_kind_q != KIND_RSI_RATIO)) begin
      if (sw_eff == '0 || cnt_q[1] < sw_eff) rdy = 1'b0;
    end
    if (signal_kind_q == KIND_RSI_RATIO && sw_eff != '0) begin
      if (cnt_q[1] < sw_eff || !ok[1]) rdy = 1'b0;
    end
  end

  always_comb begin
    logic [WIN_W-1:0]   win, cnt, head, nxt;
    logic [WIN_W-1:0]   kk;
    logic [PRICE_W-1:0] g, l, q48;
    logic               issue;

    state_d = state_q;
    u_d     = u_q;
    p_d     = p_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    tot_d   = tot_q;
    ag_d    = ag_q;
    al_d    = al_q;
    wg_d    = wg_q;
    wl_d    = wl_q;
    wc_d    = wc_q;
    last_d  = last_q;
    val_d   = val_q;
    g_d     = g_q;
    l_d     = l_q;
    big_d   = big_q;
    res_d   = res_q;
    wptr_d  = wptr_q;
    k_d     = k_q;
    v1_d    = 1'b0;
    v2_d    = v1_q;
    wt1_d   = wt1_q;
    prod_d  = prod_q;
    s_d     = s_q;
    t_d     = t_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_rdy_d   = out_rdy_q;
    u_start = 1'b0;
    u_op    = OP_MUL;
    u_a     = '0;
    u_b     = '0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = '0;
    mem_ra  = '0;

    win   = u_q ? sw_eff : fw_eff;
    cnt   = cnt_q[u_q];
    head  = head_q[u_q];
    nxt   = (head + WIN_W'(1) == win) ? '0 : head + WIN_W'(1);
    g     = (p_q > last_q[u_q]) ? p_q - last_q[u_q] : '0;
    l     = (last_q[u_q] > p_q) ? last_q[u_q] - p_q : '0;
    q48   = sat48(acc_q);
    kk    = k_q[WIN_W-1:0];
    issue = k_q <= {1'b0, cnt};
    wk    = (mean_kind == MEAN_WMA) ? WT_W'(kk)
                                    : {{WIN_W{1'b0}}, kk} * {{WIN_W{1'b0}}, kk};

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          p_d     = sample_price_i;
          u_d     = 1'b0;
          state_d = S_PUSH;
        end
      end

      // append while filling, else fetch the oldest sample to retire it
      S_PUSH: begin
        if (cnt < win) begin
          mem_we       = 1'b1;
          mem_wa       = cnt;
          tot_d[u_q]   = tot_q[u_q] + TOT_W'(p_q);
          cnt_d[u_q]   = cnt + WIN_W'(1);
          state_d      = S_RSI_CHK;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = head;
          state_d = S_PUSH_OLD;
        end
      end

      S_PUSH_OLD: begin
        mem_we      = 1'b1;
        mem_wa      = head;
        tot_d[u_q]  = tot_q[u_q] - TOT_W'(rdat) + TOT_W'(p_q);
        head_d[u_q] = nxt;
        state_d     = S_RSI_CHK;
      end

      S_RSI_CHK: begin
        if (!is_rsi || cnt < WIN_W'(2)) begin
          state_d = S_PUSH_END;
        end else begin
          g_d = g;
          l_d = l;
          if (ag_q[u_q] == '0) begin
            state_d = S_RSI_WARM;
          end else begin
            u_start = 1'b1;
            u_op    = OP_MUL;
            u_a     = DIV_W'(ag_q[u_q]);
            u_b     = OPB_W'(win - WIN_W'(1));
            state_d = S_AMUL_G;
          end
        end
      end

      // warmup: plain totals until a full window of differences is seen
      S_RSI_WARM: begin
        wg_d[u_q] = wg_q[u_q] + TOT_W'(g_q);
        wl_d[u_q] = wl_q[u_q] + TOT_W'(l_q);
        wc_d[u_q] = wc_q[u_q] + WIN_W'(1);
        state_d   = S_WARM_CHK;
      end

      S_WARM_CHK: begin
        if (wc_q[u_q] >= win) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = DIV_W'(wg_q[u_q]);
          u_b     = OPB_W'(win);
          state_d = S_WDIV_G;
        end else begin
          state_d = S_PUSH_END;
        end
      end

      S_WDIV_G: begin
        if (!u_busy_q) begin
          ag_d[u_q] = acc_q[PRICE_W-1:0];
          u_start   = 1'b1;
          u_op      = OP_DIV;
          u_a       = DIV_W'(wl_q[u_q]);
          u_b       = OPB_W'(win);
          state_d   = S_WDIV_L;
        end
      end

      S_WDIV_L: begin
        if (!u_busy_q) begin
          al_d[u_q] = acc_q[PRICE_W-1:0];
          wg_d[u_q] = '0;
          wl_d[u_q] = '0;
          wc_d[u_q] = '0;
          state_d   = S_PUSH_END;
        end
      end

      // wilder smoothing: avg = (avg * (win - 1) + term) / win
      S_AMUL_G: begin
        if (!u_busy_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = acc_q + DIV_W'(g_q);
          u_b     = OPB_W'(win);
          state_d = S_ADIV_G;
        end
      end

      S_ADIV_G: begin
        if (!u_busy_q) begin
          ag_d[u_q] = acc_q[PRICE_W-1:0];
          u_start   = 1'b1;
          u_op      = OP_MUL;
          u_a       = DIV_W'(al_q[u_q]);
          u_b       = OPB_W'(win - WIN_W'(1));
          state_d   = S_AMUL_L;
        end
      end

      S_AMUL_L: begin
        if (!u_busy_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = acc_q + DIV_W'(l_q);
          u_b     = OPB_W'(win);
          state_d = S_ADIV_L;
        end
      end

      S_ADIV_L: begin
        if (!u_busy_q) begin
          al_d[u_q] = acc_q[PRICE_W-1:0];
          state_d   = S_PUSH_END;
        end
      end

      S_PUSH_END: begin
        last_d[u_q] = p_q;
        if (!u_q && use_slow) begin
          u_d     = 1'b1;
          state_d = S_PUSH;
        end else begin
          u_d     = 1'b0;
          state_d = S_EVAL;
        end
      end

      // indicator of the current window
      S_EVAL: begin
        if (is_rsi) begin
          if (ok[u_q]) begin
            u_start = 1'b1;
            u_op    = OP_MUL;
            u_a     = DIV_W'(ag_q[u_q]);
            u_b     = COIN;
            state_d = S_RS_MUL;
          end else begin
            val_d[u_q] = '0;
            state_d    = S_EVAL_END;
          end
        end else if (cnt == '0) begin
          val_d[u_q] = '0;
          state_d    = S_EVAL_END;
        end else if (mean_kind == MEAN_SMA) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = DIV_W'(tot_q[u_q]);
          u_b     = OPB_W'(cnt);
          state_d = S_MEAN_DIV;
        end else begin
          wptr_d  = head;
          k_d     = (WIN_W + 1)'(1);
          s_d     = '0;
          t_d     = '0;
          state_d = S_WALK;
        end
      end

      S_RS_MUL: begin
        if (!u_busy_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = acc_q;
          u_b     = OPB_W'(al_q[u_q]);
          state_d = S_RS_DIV;
        end
      end

      S_RS_DIV: begin
        if (!u_busy_q) begin
          if (signal_kind_q == KIND_RSI) begin
            u_start = 1'b1;
            u_op    = OP_DIV;
            u_a     = DIV_W'(COIN_E18);
            u_b     = COIN + OPB_W'(rs_c);
            state_d = S_RSI_DIV;
          end else if (rs_c == '0) begin
            // zero rs: ratio form saturates
            val_d[u_q] = MAX48;
            state_d    = S_EVAL_END;
          end else begin
            u_start = 1'b1;
            u_op    = OP_DIV;
            u_a     = DIV_W'(COIN_SQ);
            u_b     = {rs_c, 1'b0};
            state_d = S_RRV_DIV;
          end
        end
      end

      S_RSI_DIV: begin
        if (!u_busy_q) begin
          val_d[u_q] = PRICE_W'(RSI_TOP) - acc_q[PRICE_W-1:0];
          state_d    = S_EVAL_END;
        end
      end

      S_RRV_DIV: begin
        if (!u_busy_q) begin
          val_d[u_q] = sat48(acc_q + DIV_W'(HALF_COIN));
          state_d    = S_EVAL_END;
        end
      end

      // weights k or k*k, oldest sample lightest
      S_WALK: begin
        if (issue) begin
          mem_re = 1'b1;
          mem_ra = wptr_q;
          wptr_d = (wptr_q + WIN_W'(1) == win) ? '0 : wptr_q + WIN_W'(1);
          k_d    = k_q + (WIN_W + 1)'(1);
          v1_d   = 1'b1;
          wt1_d  = wk;
          t_d    = t_q + T_W'(wk);
        end
        if (v1_q) prod_d = PROD_W'(rdat) * PROD_W'(wt1_q);
        if (v2_q) s_d = s_q + SUM_W'(prod_q);
        if (!issue && !v1_q && !v2_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = DIV_W'(s_q);
          u_b     = OPB_W'(t_q);
          state_d = S_MEAN_DIV;
        end
      end

      S_MEAN_DIV: begin
        if (!u_busy_q) begin
          val_d[u_q] = q48;
          state_d    = S_EVAL_END;
        end
      end

      // combine the windows
      S_EVAL_END: begin
        if (!u_q && use_slow) begin
          u_d     = 1'b1;
          state_d = S_EVAL;
        end else begin
          u_d = 1'b0;
          if (!signal_kind_q[2]) begin
            res_d   = val_q[0];
            state_d = S_FINAL;
          end else if (sw_eff == '0) begin
            res_d   = (signal_kind_q == KIND_RSI_RATIO) ? val_q[0] : '0;
            state_d = S_FINAL;
          end else if (val_q[0] == '0 || val_q[1] == '0) begin
            res_d   = '0;
            state_d = S_FINAL;
          end else begin
            u_start = 1'b1;
            u_op    = OP_MUL;
            u_a     = DIV_W'(val_q[0]);
            u_b     = COIN;
            state_d = S_RAT_MUL;
          end
        end
      end

      S_RAT_MUL: begin
        if (!u_busy_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = acc_q;
          u_b     = OPB_W'(val_q[1]);
          state_d = S_RAT_DIV;
        end
      end

      // quotient at least one: scale up by the weight, else down
      S_RAT_DIV: begin
        if (!u_busy_q) begin
          big_d   = 64'(q48) >= COIN;
          u_start = 1'b1;
          u_op    = OP_MUL;
          u_a     = DIV_W'(q48);
          u_b     = (64'(q48) >= COIN) ? OPB_W'(w_eff) : COIN;
          state_d = S_RAT_MUL2;
        end
      end

      S_RAT_MUL2: begin
        if (!u_busy_q) begin
          u_start = 1'b1;
          u_op    = OP_DIV;
          u_a     = acc_q;
          u_b     = big_q ? COIN : OPB_W'(w_eff);
          state_d = S_RAT_DIV2;
        end
      end

      S_RAT_DIV2: begin
        if (!u_busy_q) begin
          res_d   = q48;
          state_d = S_FINAL;
        end
      end

      S_FINAL: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_q;
          out_rdy_d   = rdy;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // any register write empties the windows
    if (cfg_we_i) begin
      for (int i = 0; i < 2; i++) begin
        cnt_d[i]  = '0;
        head_d[i] = '0;
        tot_d[i]  = '0;
        ag_d[i]   = '0;
        al_d[i]   = '0;
        wg_d[i]   = '0;
        wl_d[i]   = '0;
        wc_d[i]   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      u_q         <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tot_q[i]  <= '0;
        ag_q[i]   <= '0;
        al_q[i]   <= '0;
        wg_q[i]   <= '0;
        wl_q[i]   <= '0;
        wc_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      u_q         <= u_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tot_q       <= tot_d;
      ag_q        <= ag_d;
      al_q        <= al_d;
      wg_q        <= wg_d;
      wl_q        <= wl_d;
      wc_q        <= wc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    last_q    <= last_d;
    val_q     <= val_d;
    g_q       <= g_d;
    l_q       <= l_d;
    big_q     <= big_d;
    res_q     <= res_d;
    wptr_q    <= wptr_d;
    k_q       <= k_d;
    wt1_q     <= wt1_d;
    prod_q    <= prod_d;
    s_q       <= s_d;
    t_q       <= t_d;
    out_val_q <= out_val_d;
    out_rdy_q <= out_rdy_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign signal_value_o = out_val_q;
  assign signal_ready_o = out_rdy_q;

  // ---------------------------------------------------------------- checks
  a_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_start |-> !u_busy_q)
    else $error("shared unit started while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_start && u_op == OP_DIV) |-> (u_b != '0))
    else $error("division by zero issued");

  a_fast_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= fw_eff)
    else $error("fast window holds more samples than its length");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_PUSH))
    else $error("accepted item did not start a push");

endmodule
